// ----- sv/rtc_cal_pkg.sv -----
package rtc_cal_pkg;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_TWELVE_HOUR = 1'b0,
      CSR_ZONE_SHIFT  = 1'b1
   } csr_index_type;

   localparam logic [5:0]  SecondsPerMinute = 6'd60;
   localparam logic [5:0]  MinutesPerHour   = 6'd60;
   localparam logic [4:0]  HoursPerDay      = 5'd24;
   localparam logic [4:0]  HoursHalfDay     = 5'd12;
   localparam logic [3:0]  MonthsPerYear    = 4'd12;
   localparam logic [13:0] YearMax          = 14'd9999;
   localparam logic [13:0] YearReset        = 14'd2000;

   // floor(y / 100) for y < 16384 as (y * 5243) >> 19
   localparam logic [27:0] CenturyRecip     = 28'd5243;
   localparam int unsigned CenturyShift     = 19;

   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 48;

   typedef struct packed {
      cmd_type     cmd;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } item_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } cal_type;

   typedef struct packed {
      logic [4:0]  shown_hour;
      logic        is_pm;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        load_error;
   } rsp_type;

   typedef struct packed {
      logic       twelve_hour;
      logic [4:0] zone_shift;
   } cfg_type;

   function automatic logic is_leap(input logic [13:0] year);
      logic [27:0] prod;
      logic [7:0]  cent;
      logic [13:0] back;
      logic        div100;
      prod   = 28'(year) * CenturyRecip;
      cent   = prod[CenturyShift +: 8];
      back   = 14'({6'd0, cent} * 14'd100);
      div100 = (back == year);
      return (year[1:0] == 2'd0) && (!div100 || (cent[1:0] == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month,
                                            input logic [13:0] year);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:    len = is_leap(year) ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- sv/rtc_cal_in_reg.sv -----
module rtc_cal_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rtc_cal_pkg::item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rtc_cal_pkg::item_type out_item
);
   import rtc_cal_pkg::*;

   logic     valid_ff;
   item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

// ----- sv/rtc_cal_step.sv -----
module rtc_cal_step (
   input  rtc_cal_pkg::cal_type  cur,
   input  rtc_cal_pkg::item_type item,
   input  rtc_cal_pkg::cfg_type  cfg,
   output rtc_cal_pkg::cal_type  nxt,
   output rtc_cal_pkg::rsp_type  rsp
);
   import rtc_cal_pkg::*;

   logic       load_ok;
   logic [4:0] zone;
   logic [4:0] load_len;
   logic [4:0] cur_len;
   logic [4:0] shifted_hour;
   cal_type    ticked;
   logic       pm;
   logic [4:0] shown;

   assign load_len = month_len(item.month, item.year);
   assign cur_len  = month_len(cur.month, cur.year);
   assign zone     = (cfg.zone_shift >= HoursPerDay) ? cfg.zone_shift - HoursPerDay
                                                     : cfg.zone_shift;

   always_comb begin
      load_ok = (item.hour < HoursPerDay) && (item.minute < MinutesPerHour)
             && (item.second < SecondsPerMinute) && (item.year <= YearMax)
             && (item.month != 4'd0) && (item.month <= MonthsPerYear)
             && (item.day != 5'd0) && (item.day <= load_len);
      shifted_hour = (item.hour >= zone) ? item.hour - zone
                                         : item.hour + HoursPerDay - zone;
   end

   // carry cascade for one second
   always_comb begin
      ticked = cur;
      if (cur.second != SecondsPerMinute - 6'd1) begin
         ticked.second = cur.second + 6'd1;
      end else begin
         ticked.second = 6'd0;
         if (cur.minute != MinutesPerHour - 6'd1) begin
            ticked.minute = cur.minute + 6'd1;
         end else begin
            ticked.minute = 6'd0;
            if (cur.hour != HoursPerDay - 5'd1) begin
               ticked.hour = cur.hour + 5'd1;
            end else begin
               ticked.hour = 5'd0;
               if (cur.day < cur_len) begin
                  ticked.day = cur.day + 5'd1;
               end else begin
                  ticked.day = 5'd1;
                  if (cur.month < MonthsPerYear) begin
                     ticked.month = cur.month + 4'd1;
                  end else begin
                     ticked.month = 4'd1;
                     ticked.year  = (cur.year >= YearMax) ? 14'd0 : cur.year + 14'd1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      nxt = cur;
      rsp.load_error = 1'b0;
      unique case (item.cmd)
         CMD_LOAD: begin
            if (load_ok) begin
               nxt.hour   = shifted_hour;
               nxt.minute = item.minute;
               nxt.second = item.second;
               nxt.day    = item.day;
               nxt.month  = item.month;
               nxt.year   = item.year;
            end else begin
               rsp.load_error = 1'b1;
            end
         end
         CMD_TICK: nxt = ticked;
         default:  nxt = cur;
      endcase

      pm    = (nxt.hour >= HoursHalfDay);
      shown = nxt.hour;
      if (cfg.twelve_hour) begin
         if (nxt.hour == 5'd0) begin
            shown = HoursHalfDay;
         end else if (nxt.hour > HoursHalfDay) begin
            shown = nxt.hour - HoursHalfDay;
         end
      end

      rsp.shown_hour = shown;
      rsp.is_pm      = pm;
      rsp.minute     = nxt.minute;
      rsp.second     = nxt.second;
      rsp.day        = nxt.day;
      rsp.month      = nxt.month;
      rsp.year       = nxt.year;
   end

endmodule

// ----- sv/rtc_calendar_clock_core.sv -----
// Real-time clock with Gregorian calendar.
// req channel: one transfer per item. req_tuser is the command (0 tick one
// second, 1 load time and date); req_tdata carries the load fields.
// rsp channel: one transfer per item, showing time and date after the item;
// rsp_tuser is set when a load was rejected and the clock was left as it was.
// csr channel: csr_index 0 selects 12-hour display, 1 the zone shift in hours
// subtracted from a loaded hour; always ready, write only while idle.
// A req transfer reaches rsp_tvalid through the input register, then the result
// register that also updates the calendar state.
// Throughput: 1 item per cycle while rsp is not stalled; the whole carry
// cascade and load check are done combinationally between the two registers.
// Reset: time 00:00:00, date 2000-01-01, 24-hour mode, zero shift, both
// channels empty.
// A stalled rsp holds its result; an empty input register still takes one
// more item, then req_tready falls until the result is taken.
module rtc_calendar_clock_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] load_hour, [10:5] load_minute, [16:11] load_second,
   // [21:17] load_day, [25:22] load_month, [39:26] load_year
   input  logic [39:0] req_tdata,
   // [0] cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] shown_hour, [5] is_pm, [11:6] cur_minute, [17:12] cur_second,
   // [22:18] cur_day, [26:23] cur_month, [40:27] cur_year, [47:41] zero
   output logic [47:0] rsp_tdata,
   // [0] load_error
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);
   import rtc_cal_pkg::*;

   item_type req_item;
   item_type s1_item;
   logic     s1_valid;
   logic     s2_advance;
   cfg_type  cfg_ff;
   cal_type  state_ff;
   cal_type  state_in;
   rsp_type  rsp_in;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;

   assign req_item.cmd    = cmd_type'(req_tuser);
   assign req_item.hour   = req_tdata[4:0];
   assign req_item.minute = req_tdata[10:5];
   assign req_item.second = req_tdata[16:11];
   assign req_item.day    = req_tdata[21:17];
   assign req_item.month  = req_tdata[25:22];
   assign req_item.year   = req_tdata[39:26];

   assign s2_advance = !rsp_valid_ff || rsp_tready;

   rtc_cal_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_ready (s2_advance),
      .out_item  (s1_item)
   );

   rtc_cal_step u_step (
      .cur  (state_ff),
      .item (s1_item),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TWELVE_HOUR: cfg_ff.twelve_hour <= csr_data[0];
            CSR_ZONE_SHIFT:  cfg_ff.zone_shift  <= csr_data;
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.second <= 6'd0;
         state_ff.minute <= 6'd0;
         state_ff.hour   <= 5'd0;
         state_ff.day    <= 5'd1;
         state_ff.month  <= 4'd1;
         state_ff.year   <= YearReset;
         rsp_valid_ff    <= 1'b0;
      end else if (s2_advance) begin
         rsp_valid_ff <= s1_valid;
         if (s1_valid) begin
            state_ff <= state_in;
         end
      end
      if (s2_advance && s1_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.load_error;
   assign rsp_tdata  = {7'd0, rsp_ff.year, rsp_ff.month, rsp_ff.day, rsp_ff.second,
                        rsp_ff.minute, rsp_ff.is_pm, rsp_ff.shown_hour};

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.second < SecondsPerMinute) && (state_ff.minute < MinutesPerHour)
      && (state_ff.hour < HoursPerDay) && (state_ff.day != 5'd0)
      && (state_ff.month != 4'd0) && (state_ff.month <= MonthsPerYear)
      && (state_ff.year <= YearMax))
      else $error("calendar state out of range");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_advance && s1_valid && rsp_in.load_error) |=> $stable(state_ff))
      else $error("rejected load changed the calendar");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule
